// ----- rtl/ffa_pkg.sv -----
// ffa_pkg: shared types, sizes and helpers of the first-fit block allocator
// used by ffa_table, ffa_match and first_fit_block_allocator; no dependencies
package ffa_pkg;

    // arena geometry; the alignment is a power of two
    localparam int ARENA_BYTES  = 1 << 20;
    localparam int ALIGN_BYTES  = 16;
    localparam int HEADER_BYTES = 32;
    localparam int MAX_BLOCKS   = 256;

    localparam int OFF_W  = 20;
    localparam int REQ_W  = 21;
    localparam int CALC_W = 24;
    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = IDX_W + 1;

    localparam logic [CALC_W-1:0] HDR   = CALC_W'(HEADER_BYTES);
    localparam logic [CALC_W-1:0] ALIGN = CALC_W'(ALIGN_BYTES);
    localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_BLOCKS);

    // request codes
    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_RESIZE = 2'd2;

    // one entry of the block table
    typedef struct packed {
        logic [OFF_W-1:0] start;
        logic [OFF_W-1:0] size;
        logic             is_free;
    } entry_t;

    // compare results for the entry under inspection
    typedef struct packed {
        logic fit;
        logic hit;
    } match_t;

    typedef enum logic [4:0] {
        ST_INIT, ST_IDLE,
        ST_FIT_RD, ST_FIT_CHK, ST_UP_RD, ST_UP_WR, ST_INS, ST_TAKE,
        ST_USE_RD, ST_USE_CHK, ST_NB_RD, ST_NB_CHK, ST_GROW,
        ST_DN_RD, ST_DN_WR, ST_CO_RD, ST_CO_CHK, ST_CO_END, ST_DONE
    } state_t;

    // size rounded up to the alignment, zero counts as one
    function automatic logic [CALC_W-1:0] round_up(input logic [REQ_W-1:0] n);
        logic [CALC_W-1:0] t;
        t = (n == '0) ? CALC_W'(1) : CALC_W'(n);
        t = (t + ALIGN - CALC_W'(1)) & ~(ALIGN - CALC_W'(1));
        return t;
    endfunction

endpackage

// ----- rtl/ffa_table.sv -----
// ffa_table: block table memory, one write port and one registered read port
// depends on ffa_pkg
module ffa_table (
    input  logic                     clk,
    input  logic                     we,
    input  logic [ffa_pkg::IDX_W-1:0] waddr,
    input  ffa_pkg::entry_t          wdata,
    input  logic [ffa_pkg::IDX_W-1:0] raddr,
    output ffa_pkg::entry_t          rdata
);

    ffa_pkg::entry_t mem_reg [ffa_pkg::MAX_BLOCKS];
    ffa_pkg::entry_t rdata_reg;

    // write and registered read
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ffa_match.sv -----
// ffa_match: shared compare unit, tests one table entry for fit and for owner
// depends on ffa_pkg
module ffa_match (
    input  ffa_pkg::entry_t              ent,
    input  logic [ffa_pkg::CALC_W-1:0]   want,
    input  logic [ffa_pkg::OFF_W-1:0]    off,
    output ffa_pkg::match_t              res
);

    // free and large enough, or allocated with this payload offset
    always_comb begin
        res.fit = ent.is_free && (ffa_pkg::CALC_W'(ent.size) >= want);
        res.hit = !ent.is_free &&
                  ((ffa_pkg::CALC_W'(ent.start) + ffa_pkg::HDR) == ffa_pkg::CALC_W'(off));
    end

endmodule

// ----- rtl/first_fit_block_allocator.sv -----
// first_fit_block_allocator: first-fit allocator with coalescing over a block table
// depends on ffa_pkg, ffa_table, ffa_match
//
// Usage: an item on s_ (operation, request_bytes, payload_offset) is taken when
// s_valid and s_ready are high; allocate, free or resize. One result item per
// request leaves on m_ (ok, result_offset, relocated, copy_bytes).
// The block table sits in a single-port-read memory; every visit of an entry
// is an address state, then registered data through the compare unit.
// A request makes up to five passes over the table: owner search, first-fit
// search, a shift for a split or a merge, a second owner search after a move,
// and a coalescing pass. s_ready is high only while the sequencer is idle; one
// request at a time. A finished result waits in the output register; while
// m_ready is low the next request may still be accepted and worked on, and it
// waits for the output register before finishing. After reset the ST_INIT state
// writes the single free block into entry 0; entries above the block count are
// never read, so the table needs no clearing pass.
module first_fit_block_allocator (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_operation,
    input  logic [ffa_pkg::REQ_W-1:0]   s_request_bytes,
    input  logic [ffa_pkg::OFF_W-1:0]   s_payload_offset,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_ok,
    output logic [ffa_pkg::OFF_W-1:0]   m_result_offset,
    output logic                        m_relocated,
    output logic [ffa_pkg::REQ_W-1:0]   m_copy_bytes
);

    localparam int IW = ffa_pkg::IDX_W;
    localparam int CW = ffa_pkg::CNT_W;
    localparam int AW = ffa_pkg::CALC_W;
    localparam int OW = ffa_pkg::OFF_W;
    localparam int RW = ffa_pkg::REQ_W;

    ffa_pkg::state_t state_reg, state_next;
    logic [1:0]    op_reg, op_next;
    logic [RW-1:0] req_reg, req_next;
    logic [OW-1:0] off_reg, off_next;
    logic [AW-1:0] want_reg, want_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] w_reg, w_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [OW-1:0] ust_reg, ust_next;
    logic [OW-1:0] usz_reg, usz_next;
    logic [IW-1:0] fidx_reg, fidx_next;
    logic [OW-1:0] fst_reg, fst_next;
    logic [OW-1:0] fsz_reg, fsz_next;
    logic          split_reg, split_next;
    logic          reloc_reg, reloc_next;
    ffa_pkg::entry_t acc_reg, acc_next;
    logic          rok_reg, rok_next;
    logic [OW-1:0] roff_reg, roff_next;
    logic          rrel_reg, rrel_next;
    logic [RW-1:0] rcopy_reg, rcopy_next;
    logic          m_valid_reg, m_valid_next;
    logic          m_ok_reg, m_ok_next;
    logic [OW-1:0] m_off_reg, m_off_next;
    logic          m_rel_reg, m_rel_next;
    logic [RW-1:0] m_copy_reg, m_copy_next;

    logic            mem_we;
    logic [IW-1:0]   mem_waddr;
    ffa_pkg::entry_t mem_wdata;
    logic [IW-1:0]   mem_raddr;
    ffa_pkg::entry_t rd_ent;
    ffa_pkg::match_t hit_res;

    logic [AW-1:0] grow_sz;
    logic [AW-1:0] fit_sz;
    ffa_pkg::entry_t co_ent;

    ffa_table u_table (
        .clk   (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rd_ent)
    );

    ffa_match u_match (
        .ent  (rd_ent),
        .want (want_reg),
        .off  (off_reg),
        .res  (hit_res)
    );

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ffa_pkg::ST_INIT;
            count_reg   <= CW'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg     <= op_next;
        req_reg    <= req_next;
        off_reg    <= off_next;
        want_reg   <= want_next;
        k_reg      <= k_next;
        w_reg      <= w_next;
        idx_reg    <= idx_next;
        ust_reg    <= ust_next;
        usz_reg    <= usz_next;
        fidx_reg   <= fidx_next;
        fst_reg    <= fst_next;
        fsz_reg    <= fsz_next;
        split_reg  <= split_next;
        reloc_reg  <= reloc_next;
        acc_reg    <= acc_next;
        rok_reg    <= rok_next;
        roff_reg   <= roff_next;
        rrel_reg   <= rrel_next;
        rcopy_reg  <= rcopy_next;
        m_ok_reg   <= m_ok_next;
        m_off_reg  <= m_off_next;
        m_rel_reg  <= m_rel_next;
        m_copy_reg <= m_copy_next;
    end

    // helper sums for merge and coalescing
    always_comb begin
        grow_sz = AW'(usz_reg) + ffa_pkg::HDR + AW'(rd_ent.size);
        fit_sz  = AW'(rd_ent.size);
        co_ent  = rd_ent;
        co_ent.is_free = rd_ent.is_free || (k_reg[IW-1:0] == idx_reg);
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        req_next     = req_reg;
        off_next     = off_reg;
        want_next    = want_reg;
        count_next   = count_reg;
        k_next       = k_reg;
        w_next       = w_reg;
        idx_next     = idx_reg;
        ust_next     = ust_reg;
        usz_next     = usz_reg;
        fidx_next    = fidx_reg;
        fst_next     = fst_reg;
        fsz_next     = fsz_reg;
        split_next   = split_reg;
        reloc_next   = reloc_reg;
        acc_next     = acc_reg;
        rok_next     = rok_reg;
        roff_next    = roff_reg;
        rrel_next    = rrel_reg;
        rcopy_next   = rcopy_reg;
        m_ok_next    = m_ok_reg;
        m_off_next   = m_off_reg;
        m_rel_next   = m_rel_reg;
        m_copy_next  = m_copy_reg;
        m_valid_next = m_valid_reg && !m_ready;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_raddr    = '0;
        s_ready      = 1'b0;

        case (state_reg)
            // single free block covering the arena
            ffa_pkg::ST_INIT: begin
                mem_we          = 1'b1;
                mem_wdata.start = '0;
                mem_wdata.size  = OW'(ffa_pkg::ARENA_BYTES - ffa_pkg::HEADER_BYTES);
                mem_wdata.is_free = 1'b1;
                count_next = CW'(1);
                state_next = ffa_pkg::ST_IDLE;
            end
            // take a request and pick the first pass
            ffa_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next    = s_operation;
                    req_next   = s_request_bytes;
                    off_next   = s_payload_offset;
                    want_next  = ffa_pkg::round_up(s_request_bytes);
                    k_next     = '0;
                    reloc_next = 1'b0;
                    rok_next   = 1'b0;
                    roff_next  = '0;
                    rrel_next  = 1'b0;
                    rcopy_next = '0;
                    if (s_operation == ffa_pkg::OP_ALLOC) begin
                        state_next = ffa_pkg::ST_FIT_RD;
                    end else if (s_operation == ffa_pkg::OP_FREE) begin
                        if (s_payload_offset == '0) begin
                            rok_next   = 1'b1;
                            state_next = ffa_pkg::ST_DONE;
                        end else begin
                            state_next = ffa_pkg::ST_USE_RD;
                        end
                    end else if (s_operation == ffa_pkg::OP_RESIZE) begin
                        if (s_payload_offset == '0) begin
                            state_next = ffa_pkg::ST_FIT_RD;
                        end else begin
                            state_next = ffa_pkg::ST_USE_RD;
                        end
                    end else begin
                        state_next = ffa_pkg::ST_DONE;
                    end
                end
            end
            // first-fit search
            ffa_pkg::ST_FIT_RD: begin
                if (k_reg < count_reg) begin
                    mem_raddr  = k_reg[IW-1:0];
                    state_next = ffa_pkg::ST_FIT_CHK;
                end else begin
                    rok_next   = 1'b0;
                    roff_next  = '0;
                    rrel_next  = 1'b0;
                    rcopy_next = '0;
                    state_next = ffa_pkg::ST_DONE;
                end
            end
            ffa_pkg::ST_FIT_CHK: begin
                if (hit_res.fit) begin
                    fidx_next  = k_reg[IW-1:0];
                    fst_next   = rd_ent.start;
                    fsz_next   = rd_ent.size;
                    split_next = (fit_sz >= want_reg + ffa_pkg::HDR + ffa_pkg::ALIGN) &&
                                 (count_reg < ffa_pkg::MAX_CNT);
                    if ((fit_sz >= want_reg + ffa_pkg::HDR + ffa_pkg::ALIGN) &&
                        (count_reg < ffa_pkg::MAX_CNT)) begin
                        k_next     = count_reg - CW'(1);
                        state_next = ffa_pkg::ST_UP_RD;
                    end else begin
                        state_next = ffa_pkg::ST_TAKE;
                    end
                end else begin
                    k_next     = k_reg + CW'(1);
                    state_next = ffa_pkg::ST_FIT_RD;
                end
            end
            // open a slot after the chosen block, top entry first
            ffa_pkg::ST_UP_RD: begin
                if (k_reg > CW'(fidx_reg)) begin
                    mem_raddr  = k_reg[IW-1:0];
                    state_next = ffa_pkg::ST_UP_WR;
                end else begin
                    state_next = ffa_pkg::ST_INS;
                end
            end
            ffa_pkg::ST_UP_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = IW'(k_reg + CW'(1));
                mem_wdata  = rd_ent;
                k_next     = k_reg - CW'(1);
                state_next = ffa_pkg::ST_UP_RD;
            end
            // free remainder of the split
            ffa_pkg::ST_INS: begin
                mem_we            = 1'b1;
                mem_waddr         = fidx_reg + IW'(1);
                mem_wdata.start   = OW'(AW'(fst_reg) + ffa_pkg::HDR + want_reg);
                mem_wdata.size    = OW'(AW'(fsz_reg) - want_reg - ffa_pkg::HDR);
                mem_wdata.is_free = 1'b1;
                count_next        = count_reg + CW'(1);
                state_next        = ffa_pkg::ST_TAKE;
            end
            // mark the chosen block allocated
            ffa_pkg::ST_TAKE: begin
                mem_we            = 1'b1;
                mem_waddr         = fidx_reg;
                mem_wdata.start   = fst_reg;
                mem_wdata.size    = split_reg ? OW'(want_reg) : fsz_reg;
                mem_wdata.is_free = 1'b0;
                rok_next          = 1'b1;
                roff_next         = OW'(AW'(fst_reg) + ffa_pkg::HDR);
                if (reloc_reg) begin
                    rrel_next  = 1'b1;
                    rcopy_next = (RW'(usz_reg) < req_reg) ? RW'(usz_reg) : req_reg;
                    k_next     = '0;
                    state_next = ffa_pkg::ST_USE_RD;
                end else begin
                    state_next = ffa_pkg::ST_DONE;
                end
            end
            // owner search by payload offset
            ffa_pkg::ST_USE_RD: begin
                if (k_reg < count_reg) begin
                    mem_raddr  = k_reg[IW-1:0];
                    state_next = ffa_pkg::ST_USE_CHK;
                end else begin
                    if (!reloc_reg) begin
                        rok_next  = 1'b0;
                        roff_next = '0;
                    end
                    state_next = ffa_pkg::ST_DONE;
                end
            end
            ffa_pkg::ST_USE_CHK: begin
                if (hit_res.hit) begin
                    idx_next = k_reg[IW-1:0];
                    ust_next = rd_ent.start;
                    usz_next = rd_ent.size;
                    if (reloc_reg || (op_reg == ffa_pkg::OP_FREE) || (req_reg == '0)) begin
                        if (!reloc_reg) begin
                            rok_next  = 1'b1;
                            roff_next = '0;
                        end
                        k_next     = '0;
                        w_next     = '0;
                        state_next = ffa_pkg::ST_CO_RD;
                    end else if (fit_sz >= want_reg) begin
                        rok_next   = 1'b1;
                        roff_next  = off_reg;
                        state_next = ffa_pkg::ST_DONE;
                    end else if (k_reg + CW'(1) < count_reg) begin
                        state_next = ffa_pkg::ST_NB_RD;
                    end else begin
                        reloc_next = 1'b1;
                        k_next     = '0;
                        state_next = ffa_pkg::ST_FIT_RD;
                    end
                end else begin
                    k_next     = k_reg + CW'(1);
                    state_next = ffa_pkg::ST_USE_RD;
                end
            end
            // right neighbour for growth in place
            ffa_pkg::ST_NB_RD: begin
                mem_raddr  = idx_reg + IW'(1);
                state_next = ffa_pkg::ST_NB_CHK;
            end
            ffa_pkg::ST_NB_CHK: begin
                if (rd_ent.is_free && (grow_sz >= want_reg)) begin
                    rok_next  = 1'b1;
                    roff_next = off_reg;
                    mem_we    = 1'b1;
                    if (grow_sz >= want_reg + ffa_pkg::HDR + ffa_pkg::ALIGN) begin
                        mem_waddr         = idx_reg + IW'(1);
                        mem_wdata.start   = OW'(AW'(ust_reg) + ffa_pkg::HDR + want_reg);
                        mem_wdata.size    = OW'(grow_sz - want_reg - ffa_pkg::HDR);
                        mem_wdata.is_free = 1'b1;
                        state_next        = ffa_pkg::ST_GROW;
                    end else begin
                        mem_waddr         = idx_reg;
                        mem_wdata.start   = ust_reg;
                        mem_wdata.size    = OW'(grow_sz);
                        mem_wdata.is_free = 1'b0;
                        k_next            = CW'(idx_reg) + CW'(2);
                        state_next        = ffa_pkg::ST_DN_RD;
                    end
                end else begin
                    reloc_next = 1'b1;
                    k_next     = '0;
                    state_next = ffa_pkg::ST_FIT_RD;
                end
            end
            ffa_pkg::ST_GROW: begin
                mem_we            = 1'b1;
                mem_waddr         = idx_reg;
                mem_wdata.start   = ust_reg;
                mem_wdata.size    = OW'(want_reg);
                mem_wdata.is_free = 1'b0;
                state_next        = ffa_pkg::ST_DONE;
            end
            // close the gap left by the absorbed neighbour
            ffa_pkg::ST_DN_RD: begin
                if (k_reg < count_reg) begin
                    mem_raddr  = k_reg[IW-1:0];
                    state_next = ffa_pkg::ST_DN_WR;
                end else begin
                    count_next = count_reg - CW'(1);
                    state_next = ffa_pkg::ST_DONE;
                end
            end
            ffa_pkg::ST_DN_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = IW'(k_reg - CW'(1));
                mem_wdata  = rd_ent;
                k_next     = k_reg + CW'(1);
                state_next = ffa_pkg::ST_DN_RD;
            end
            // coalescing pass, freed block taken as free, compacting in place
            ffa_pkg::ST_CO_RD: begin
                mem_raddr  = k_reg[IW-1:0];
                state_next = ffa_pkg::ST_CO_CHK;
            end
            ffa_pkg::ST_CO_CHK: begin
                if (k_reg == '0) begin
                    acc_next = co_ent;
                end else if (acc_reg.is_free && co_ent.is_free) begin
                    acc_next.size = OW'(AW'(acc_reg.size) + ffa_pkg::HDR + AW'(co_ent.size));
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = w_reg[IW-1:0];
                    mem_wdata = acc_reg;
                    w_next    = w_reg + CW'(1);
                    acc_next  = co_ent;
                end
                k_next = k_reg + CW'(1);
                if (k_reg + CW'(1) == count_reg) begin
                    state_next = ffa_pkg::ST_CO_END;
                end else begin
                    state_next = ffa_pkg::ST_CO_RD;
                end
            end
            ffa_pkg::ST_CO_END: begin
                mem_we     = 1'b1;
                mem_waddr  = w_reg[IW-1:0];
                mem_wdata  = acc_reg;
                count_next = w_reg + CW'(1);
                state_next = ffa_pkg::ST_DONE;
            end
            // hand the result item to the output register
            ffa_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_ok_next    = rok_reg;
                    m_off_next   = rok_reg ? roff_reg : '0;
                    m_rel_next   = rrel_reg;
                    m_copy_next  = rcopy_reg;
                    state_next   = ffa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ffa_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_ok            = m_ok_reg;
    assign m_result_offset = m_off_reg;
    assign m_relocated     = m_rel_reg;
    assign m_copy_bytes    = m_copy_reg;

`ifndef NO_ASSERTIONS
    // block count stays within the table
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) && (count_reg <= ffa_pkg::MAX_CNT))
        else $error("block count out of range");

    // a failed item carries a null offset
    a_fail_null: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ok) |-> (m_result_offset == '0))
        else $error("failed item with non-null offset");

    // relocation only on success
    a_reloc_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_relocated) |-> m_ok)
        else $error("relocation reported on failure");

    // busy after taking an item
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready right after accept");
`endif

endmodule

// ----- tb/first_fit_block_allocator_tb.sv -----
// first_fit_block_allocator_tb: self-checking testbench of the first-fit block allocator
// drives allocate, free and resize requests and checks every result against its own
// block table model; depends on ffa_pkg and first_fit_block_allocator
module first_fit_block_allocator_tb;

    localparam int CYCLE_LIMIT = 20000000;

    // operation code with no defined meaning
    localparam logic [1:0] OP_UNDEF = 2'd3;

    typedef struct {
        logic                      ok;
        logic [ffa_pkg::OFF_W-1:0] offset;
        logic                      moved;
        logic [ffa_pkg::REQ_W-1:0] copy_len;
    } reply_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [1:0]                 s_operation = ffa_pkg::OP_ALLOC;
    logic [ffa_pkg::REQ_W-1:0]  s_request_bytes = '0;
    logic [ffa_pkg::OFF_W-1:0]  s_payload_offset = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic                       m_ok;
    logic [ffa_pkg::OFF_W-1:0]  m_result_offset;
    logic                       m_relocated;
    logic [ffa_pkg::REQ_W-1:0]  m_copy_bytes;

    // model of the block table
    int unsigned blk_start [ffa_pkg::MAX_BLOCKS];
    int unsigned blk_size [ffa_pkg::MAX_BLOCKS];
    bit          blk_free [ffa_pkg::MAX_BLOCKS];
    int unsigned blk_count;

    reply_t      replies_due[$];
    int unsigned live_offsets[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          hold_off = 0;
    int          burst_left = 0;

    first_fit_block_allocator DUT (.*);

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // runaway guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int unsigned rounded(int unsigned n);
        if (n == 0) n = 1;
        return ((n + ffa_pkg::ALIGN_BYTES - 1) / ffa_pkg::ALIGN_BYTES) * ffa_pkg::ALIGN_BYTES;
    endfunction

    function automatic void tbl_insert(int unsigned i, int unsigned st, int unsigned sz);
        for (int unsigned k = blk_count; k > i + 1; k--) begin
            blk_start[k] = blk_start[k-1];
            blk_size[k] = blk_size[k-1];
            blk_free[k] = blk_free[k-1];
        end
        blk_start[i+1] = st;
        blk_size[i+1] = sz;
        blk_free[i+1] = 1'b1;
        blk_count++;
    endfunction

    function automatic void tbl_remove(int unsigned i);
        for (int unsigned k = i; k + 1 < blk_count; k++) begin
            blk_start[k] = blk_start[k+1];
            blk_size[k] = blk_size[k+1];
            blk_free[k] = blk_free[k+1];
        end
        blk_count--;
    endfunction

    function automatic void tbl_split(int unsigned i, int unsigned want);
        if (blk_size[i] >= want + ffa_pkg::HEADER_BYTES + ffa_pkg::ALIGN_BYTES &&
            blk_count < ffa_pkg::MAX_BLOCKS) begin
            tbl_insert(i, blk_start[i] + ffa_pkg::HEADER_BYTES + want,
                       blk_size[i] - want - ffa_pkg::HEADER_BYTES);
            blk_size[i] = want;
        end
    endfunction

    function automatic void tbl_merge();
        int unsigned i;
        i = 0;
        while (i + 1 < blk_count) begin
            if (blk_free[i] && blk_free[i+1]) begin
                blk_size[i] += ffa_pkg::HEADER_BYTES + blk_size[i+1];
                tbl_remove(i + 1);
            end else begin
                i++;
            end
        end
    endfunction

    function automatic int unsigned take_first_fit(int unsigned req, output bit ok);
        int unsigned want;
        want = rounded(req);
        for (int unsigned i = 0; i < blk_count; i++) begin
            if (blk_free[i] && blk_size[i] >= want) begin
                tbl_split(i, want);
                blk_free[i] = 1'b0;
                ok = 1'b1;
                return blk_start[i] + ffa_pkg::HEADER_BYTES;
            end
        end
        ok = 1'b0;
        return 0;
    endfunction

    function automatic int unsigned find_taken(int unsigned off);
        for (int unsigned i = 0; i < blk_count; i++)
            if (!blk_free[i] && blk_start[i] + ffa_pkg::HEADER_BYTES == off) return i;
        return blk_count;
    endfunction

    function automatic void forget_offset(int unsigned off);
        foreach (live_offsets[k])
            if (live_offsets[k] == off) begin
                live_offsets.delete(k);
                return;
            end
    endfunction

    // predicted result of one request, updating the table
    function automatic reply_t predict_reply(logic [1:0] op, int unsigned req,
                                             int unsigned off);
        reply_t r;
        bit ok;
        int unsigned i, want, oldsz, res;
        ok = 0; res = 0; r.moved = 0; r.copy_len = '0;
        if (op == ffa_pkg::OP_ALLOC || (op == ffa_pkg::OP_RESIZE && off == 0)) begin
            res = take_first_fit(req, ok);
        end else if (op == ffa_pkg::OP_FREE) begin
            if (off == 0) ok = 1;
            else begin
                i = find_taken(off);
                if (i < blk_count) begin
                    blk_free[i] = 1; tbl_merge(); ok = 1;
                end
            end
        end else if (op == ffa_pkg::OP_RESIZE) begin
            i = find_taken(off);
            if (i < blk_count) begin
                want = rounded(req);
                if (req == 0) begin
                    blk_free[i] = 1; tbl_merge(); ok = 1;
                end else if (blk_size[i] >= want) begin
                    ok = 1; res = off;
                end else if (i + 1 < blk_count && blk_free[i+1] &&
                             blk_size[i] + ffa_pkg::HEADER_BYTES + blk_size[i+1] >= want) begin
                    blk_size[i] += ffa_pkg::HEADER_BYTES + blk_size[i+1];
                    tbl_remove(i + 1);
                    tbl_split(i, want);
                    ok = 1; res = off;
                end else begin
                    oldsz = blk_size[i];
                    res = take_first_fit(req, ok);
                    if (ok) begin
                        r.copy_len = ffa_pkg::REQ_W'((oldsz < req) ? oldsz : req);
                        r.moved = 1;
                        i = find_taken(off);
                        if (i < blk_count) begin
                            blk_free[i] = 1; tbl_merge();
                        end
                    end
                end
            end
        end
        if (!ok) res = 0;
        r.ok = ok;
        r.offset = ffa_pkg::OFF_W'(res);
        // keep track of live payloads for later frees and resizes
        if (op == ffa_pkg::OP_FREE && ok) forget_offset(off);
        if (op == ffa_pkg::OP_RESIZE && ok && off != 0 && res != off) forget_offset(off);
        if (ok && res != 0 && res != off) live_offsets.push_back(res);
        return r;
    endfunction

    // sends one item, valid held through a burst, dropped for the gaps
    task automatic send_item(logic [1:0] op, int unsigned req, int unsigned off);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_operation <= op;
        s_request_bytes <= ffa_pkg::REQ_W'(req);
        s_payload_offset <= ffa_pkg::OFF_W'(off);
        do @(posedge aclk); while (!s_ready);
        replies_due.push_back(predict_reply(op, req, off));
    endtask

    function automatic int unsigned pick_live();
        if (live_offsets.size() == 0) return 0;
        return live_offsets[$urandom_range(0, live_offsets.size() - 1)];
    endfunction

    function automatic int unsigned pick_size();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1 << 20);
            1: return $urandom_range(0, 16);
            default: return $urandom_range(1, 3000);
        endcase
    endfunction

    // receiver stall pattern and long hold-off
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= (cycle_count[6:5] == 2'b00) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    // result checker
    always @(posedge aclk) begin
        reply_t e;
        if (aresetn && m_valid && m_ready) begin
            if (replies_due.size() == 0) begin
                $error("result item with nothing expected");
                fail_count++;
            end else begin
                e = replies_due.pop_front();
                if (m_ok !== e.ok) begin
                    $error("ok: expected %0d actual %0d", e.ok, m_ok); fail_count++;
                end
                if (m_result_offset !== e.offset) begin
                    $error("result_offset: expected %0h actual %0h", e.offset,
                           m_result_offset);
                    fail_count++;
                end
                if (m_relocated !== e.moved) begin
                    $error("relocated: expected %0d actual %0d", e.moved, m_relocated);
                    fail_count++;
                end
                if (m_copy_bytes !== e.copy_len) begin
                    $error("copy_bytes: expected %0d actual %0d", e.copy_len,
                           m_copy_bytes);
                    fail_count++;
                end
            end
        end
    end

    // field extremes, every operation and the named corner cases
    task automatic test_directed();
        int unsigned a;
        send_item(ffa_pkg::OP_FREE, 0, 0);
        send_item(ffa_pkg::OP_FREE, 5, 20'hFFFFF);
        send_item(ffa_pkg::OP_RESIZE, 7, 12345);
        send_item(OP_UNDEF, 21'h1FFFFF, 20'hFFFFF);
        send_item(ffa_pkg::OP_ALLOC, 21'h1FFFFF, 0);
        send_item(ffa_pkg::OP_ALLOC, 1 << 20, 0);
        send_item(ffa_pkg::OP_ALLOC, 0, 0);
        a = live_offsets[$];
        send_item(ffa_pkg::OP_RESIZE, 10, a);
        send_item(ffa_pkg::OP_ALLOC, 100, 0);
        send_item(ffa_pkg::OP_RESIZE, 200, a);
        a = live_offsets[$];
        send_item(ffa_pkg::OP_RESIZE, 5000, a);
        send_item(ffa_pkg::OP_RESIZE, 0, 0);
        send_item(ffa_pkg::OP_RESIZE, 0, pick_live());
        send_item(ffa_pkg::OP_ALLOC, (1 << 20) - 32 - 256, 0);
        send_item(ffa_pkg::OP_FREE, 0, pick_live());
        send_item(ffa_pkg::OP_FREE, 0, pick_live());
    endtask

    // drain everything and return to a clean arena
    task automatic free_all();
        while (live_offsets.size() > 0) send_item(ffa_pkg::OP_FREE, 0, live_offsets[0]);
    endtask

    // fill the table so splits are skipped
    task automatic test_table_full();
        repeat (270) send_item(ffa_pkg::OP_ALLOC, $urandom_range(1, 64), 0);
        repeat (10) send_item(ffa_pkg::OP_RESIZE, $urandom_range(1, 4000), pick_live());
        free_all();
    endtask

    // long receiver hold-off while the sender keeps going
    task automatic test_backpressure();
        hold_off = 400;
        repeat (20) send_item(ffa_pkg::OP_ALLOC, $urandom_range(0, 500), 0);
        free_all();
    endtask

    // mostly valid frees and resizes of live blocks, some noise
    task automatic test_random(int n);
        int unsigned k, off;
        for (int j = 0; j < n; j++) begin
            k = $urandom_range(0, 99);
            off = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 20'hFFFFF) : pick_live();
            if (k < 40) send_item(ffa_pkg::OP_ALLOC, pick_size(), 0);
            else if (k < 65) send_item(ffa_pkg::OP_FREE, $urandom_range(0, 21'h1FFFFF), off);
            else if (k < 98) send_item(ffa_pkg::OP_RESIZE, pick_size(), off);
            else send_item(OP_UNDEF, $urandom_range(0, 21'h1FFFFF),
                           $urandom_range(0, 20'hFFFFF));
            if (live_offsets.size() > 200) free_all();
        end
    endtask

    initial begin
        blk_start[0] = 0;
        blk_size[0] = ffa_pkg::ARENA_BYTES - ffa_pkg::HEADER_BYTES;
        blk_free[0] = 1'b1;
        blk_count = 1;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_table_full();
        test_random(1000);
        s_valid <= 1'b0;
        while (replies_due.size() > 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule
